// ===== rtl/pfat_pkg.sv =====
// Package for the page frame allocator table: widths, request kinds, status codes,
// frame types, sequencer states and the table entry and write request types.
// Used by pfat_frame_table and page_frame_allocator_table_unit.
package pfat_pkg;

  localparam int NumPages = 256;
  localparam int IdxW     = 8;   // frame index
  localparam int CntW     = 9;   // frame count, can hold NumPages
  localparam int KeyW     = 16;
  localparam int TypeW    = 3;
  localparam int KindW    = 4;
  localparam int StatW    = 3;
  localparam int DataW    = 40;  // packed request / result width

  // Request kinds
  localparam logic [KindW-1:0] KIND_RESERVE  = 4'd0;
  localparam logic [KindW-1:0] KIND_CLAIM    = 4'd1;
  localparam logic [KindW-1:0] KIND_FIND     = 4'd2;
  localparam logic [KindW-1:0] KIND_RELEASE  = 4'd3;
  localparam logic [KindW-1:0] KIND_FREE_RES = 4'd4;
  localparam logic [KindW-1:0] KIND_FREE_OWN = 4'd5;
  localparam logic [KindW-1:0] KIND_VICTIM   = 4'd6;
  localparam logic [KindW-1:0] KIND_QUERY    = 4'd7;
  localparam logic [KindW-1:0] KIND_RUN      = 4'd8;

  // Frame types
  localparam logic [TypeW-1:0] TYPE_FREE = 3'd0;
  localparam logic [TypeW-1:0] TYPE_REG  = 3'd3;
  localparam logic [TypeW-1:0] TYPE_RESV = 3'd5;

  // Result status
  localparam logic [StatW-1:0] STAT_OK    = 3'd0;
  localparam logic [StatW-1:0] STAT_NONE  = 3'd1;
  localparam logic [StatW-1:0] STAT_RANGE = 3'd2;
  localparam logic [StatW-1:0] STAT_FREE  = 3'd3;
  localparam logic [StatW-1:0] STAT_RUN   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_PAGES = 1'b0;
  localparam logic CFG_LWM   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_RUNWR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [TypeW-1:0] ptype;
    logic [KeyW-1:0]  owner;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  addr;
    entry_t           entry;
  } wr_req_t;

endpackage

// ===== rtl/pfat_frame_table.sv =====
// Frame table storage: one-write, one-read memory with registered read data,
// plus per-frame valid bits so a cleared frame reads as free with owner zero.
// Depends on pfat_pkg.
module pfat_frame_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic [pfat_pkg::IdxW-1:0] rd_addr_i,
  input  pfat_pkg::wr_req_t  wr_i,
  output pfat_pkg::entry_t   rd_entry_o
);

  pfat_pkg::entry_t                mem [pfat_pkg::NumPages];
  logic [pfat_pkg::NumPages-1:0]   valid_q;
  pfat_pkg::entry_t                rd_entry_q;
  logic                            rd_vld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    rd_entry_q <= mem[rd_addr_i];
  end

  // Valid bits: cleared at once by reset or a table clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else if (clear_i) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_vld_q ? rd_entry_q : '0;

endmodule

// ===== rtl/page_frame_allocator_table_unit.sv =====
// Page frame allocator table, top level: request sequencer, counters and result register.
// Depends on pfat_pkg and pfat_frame_table.
//
// Each scanning request walks the frame table one entry at a time through a single read
// port, ST_READ presenting the address and ST_EVAL evaluating the entry. A run request
// then checks the frames after its first free frame and writes each reserved frame in
// ST_RUNWR. Release and query requests read one entry; out-of-range requests go straight
// to ST_FIN. One request is handled at a time; s_axis_tready is high only while the
// sequencer is idle. The result waits in an output register until taken. Configuration is
// written through cfg_we_i; writing pages_in_use clears the table at once.
module page_frame_allocator_table_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [3:0] kind, [19:4] owner_key, [22:20] page_type, [30:23] page_index, [39:31] run_length
  input  logic [pfat_pkg::DataW-1:0] s_axis_tdata,
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [2:0] status, [10:3] result_index, [13:11] result_type, [29:14] result_owner,
  // [38:30] free_count, [39] below_low_water
  output logic [pfat_pkg::DataW-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                       cfg_we_i,
  input  logic                       cfg_addr_i,
  input  logic [pfat_pkg::CntW-1:0]  cfg_data_i
);

  localparam int IdxW = pfat_pkg::IdxW;
  localparam int CntW = pfat_pkg::CntW;

  pfat_pkg::state_e state_q, state_d;

  logic [pfat_pkg::KindW-1:0]  kind_q, kind_d;
  logic [pfat_pkg::KeyW-1:0]   key_q, key_d;
  logic [pfat_pkg::TypeW-1:0]  pt_q, pt_d;
  logic [CntW-1:0]             len_q, len_d;
  logic [IdxW-1:0]             addr_q, addr_d;
  logic [IdxW-1:0]             base_q, base_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [CntW-1:0]             left_q, left_d;
  logic                        phase_q, phase_d;
  logic                        hit_q, hit_d;
  logic [CntW-1:0]             free_q, free_d;
  logic [CntW-1:0]             n_q;
  logic [CntW-1:0]             lwm_q;
  logic [IdxW-1:0]             curf_q, curf_d;
  logic [IdxW-1:0]             cure_q, cure_d;
  logic [pfat_pkg::StatW-1:0]  stat_q, stat_d;
  logic [IdxW-1:0]             ridx_q, ridx_d;
  logic [pfat_pkg::TypeW-1:0]  rtype_q, rtype_d;
  logic [pfat_pkg::KeyW-1:0]   rown_q, rown_d;
  logic                        out_vld_q;
  logic [pfat_pkg::DataW-1:0]  out_q;

  pfat_pkg::entry_t  ent;
  pfat_pkg::wr_req_t wr;
  logic              tbl_clear;

  // Request fields
  logic [pfat_pkg::KindW-1:0]  in_kind;
  logic [pfat_pkg::KeyW-1:0]   in_key;
  logic [pfat_pkg::TypeW-1:0]  in_pt;
  logic [IdxW-1:0]             in_idx;
  logic [CntW-1:0]             in_len;
  assign in_kind = s_axis_tdata[3:0];
  assign in_key  = s_axis_tdata[19:4];
  assign in_pt   = s_axis_tdata[22:20];
  assign in_idx  = s_axis_tdata[30:23];
  assign in_len  = s_axis_tdata[39:31];

  logic accept;
  assign s_axis_tready = (state_q == pfat_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decoded conditions on the entry being evaluated
  logic            e_free, owner_eq, last_step, range_err, run_bad, fin_load;
  logic [IdxW-1:0] next_addr;
  logic [CntW:0]   run_end;
  logic [pfat_pkg::TypeW-1:0] claim_type;
  logic            match;

  assign e_free    = (ent.ptype == pfat_pkg::TYPE_FREE);
  assign owner_eq  = (ent.owner == key_q);
  assign last_step = ((cnt_q + 1'b1) == n_q);
  assign next_addr = ({1'b0, addr_q} == (n_q - 1'b1)) ? '0 : addr_q + 1'b1;
  assign range_err = ({1'b0, in_idx} >= n_q);
  assign run_end   = (CntW+1)'(addr_q) + {1'b0, len_q};
  assign run_bad   = (len_q == '0) || (run_end > {1'b0, n_q});
  assign claim_type = (pt_q > pfat_pkg::TYPE_RESV) ? pfat_pkg::TYPE_RESV : pt_q;
  assign fin_load  = !out_vld_q || m_axis_tready;

  // Scan match per kind
  always_comb begin
    case (kind_q)
      pfat_pkg::KIND_RESERVE,
      pfat_pkg::KIND_RUN:      match = e_free;
      pfat_pkg::KIND_CLAIM:    match = owner_eq && (ent.ptype == pfat_pkg::TYPE_RESV);
      pfat_pkg::KIND_FIND:     match = owner_eq && !e_free;
      pfat_pkg::KIND_VICTIM:   match = (ent.ptype == pfat_pkg::TYPE_REG);
      pfat_pkg::KIND_FREE_RES: match = owner_eq && (ent.ptype == pfat_pkg::TYPE_RESV);
      pfat_pkg::KIND_FREE_OWN: match = owner_eq && !e_free;
      default:                 match = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfat_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind > pfat_pkg::KIND_RUN) begin
            state_d = pfat_pkg::ST_FIN;
          end else if ((in_kind == pfat_pkg::KIND_RELEASE || in_kind == pfat_pkg::KIND_QUERY)
                       && range_err) begin
            state_d = pfat_pkg::ST_FIN;
          end else begin
            state_d = pfat_pkg::ST_READ;
          end
        end
      end
      pfat_pkg::ST_READ: state_d = pfat_pkg::ST_EVAL;
      pfat_pkg::ST_EVAL: begin
        case (kind_q)
          pfat_pkg::KIND_RELEASE,
          pfat_pkg::KIND_QUERY: state_d = pfat_pkg::ST_FIN;
          pfat_pkg::KIND_FREE_RES,
          pfat_pkg::KIND_FREE_OWN: state_d = last_step ? pfat_pkg::ST_FIN : pfat_pkg::ST_READ;
          pfat_pkg::KIND_RUN: begin
            if (!phase_q) begin
              if (!match) begin
                state_d = last_step ? pfat_pkg::ST_FIN : pfat_pkg::ST_READ;
              end else if (run_bad) begin
                state_d = pfat_pkg::ST_FIN;
              end else if (len_q == CntW'(1)) begin
                state_d = pfat_pkg::ST_RUNWR;
              end else begin
                state_d = pfat_pkg::ST_READ;
              end
            end else if (!e_free) begin
              state_d = pfat_pkg::ST_FIN;
            end else if (left_q == CntW'(1)) begin
              state_d = pfat_pkg::ST_RUNWR;
            end else begin
              state_d = pfat_pkg::ST_READ;
            end
          end
          default: state_d = (match || last_step) ? pfat_pkg::ST_FIN : pfat_pkg::ST_READ;
        endcase
      end
      pfat_pkg::ST_RUNWR: if (left_q == CntW'(1)) state_d = pfat_pkg::ST_FIN;
      pfat_pkg::ST_FIN:   if (fin_load) state_d = pfat_pkg::ST_IDLE;
      default:            state_d = pfat_pkg::ST_IDLE;
    endcase
  end

  // Datapath and table writes
  always_comb begin
    kind_d  = kind_q;
    key_d   = key_q;
    pt_d    = pt_q;
    len_d   = len_q;
    addr_d  = addr_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    phase_d = phase_q;
    hit_d   = hit_q;
    free_d  = free_q;
    curf_d  = curf_q;
    cure_d  = cure_q;
    stat_d  = stat_q;
    ridx_d  = ridx_q;
    rtype_d = rtype_q;
    rown_d  = rown_q;
    wr      = '0;

    case (state_q)
      pfat_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d  = in_kind;
          key_d   = in_key;
          pt_d    = in_pt;
          len_d   = in_len;
          cnt_d   = '0;
          phase_d = 1'b0;
          hit_d   = 1'b0;
          stat_d  = pfat_pkg::STAT_OK;
          ridx_d  = '0;
          rtype_d = '0;
          rown_d  = '0;
          case (in_kind)
            pfat_pkg::KIND_FIND:   addr_d = curf_q;
            pfat_pkg::KIND_VICTIM: addr_d = cure_q;
            pfat_pkg::KIND_RELEASE,
            pfat_pkg::KIND_QUERY: begin
              addr_d = in_idx;
              if (range_err) stat_d = pfat_pkg::STAT_RANGE;
            end
            default: addr_d = '0;
          endcase
        end
      end

      pfat_pkg::ST_EVAL: begin
        case (kind_q)
          pfat_pkg::KIND_RELEASE,
          pfat_pkg::KIND_QUERY: begin
            ridx_d  = addr_q;
            rtype_d = ent.ptype;
            rown_d  = ent.owner;
            if (kind_q == pfat_pkg::KIND_RELEASE) begin
              if (e_free) begin
                stat_d = pfat_pkg::STAT_FREE;
              end else begin
                wr.en   = 1'b1;
                wr.addr = addr_q;
                free_d  = free_q + 1'b1;
              end
            end
          end

          pfat_pkg::KIND_FREE_RES,
          pfat_pkg::KIND_FREE_OWN: begin
            rown_d = key_q;
            if (match) begin
              wr.en   = 1'b1;
              wr.addr = addr_q;
              free_d  = free_q + 1'b1;
              hit_d   = 1'b1;
            end
            if (last_step && !(match || hit_q)) stat_d = pfat_pkg::STAT_NONE;
            addr_d = next_addr;
            cnt_d  = cnt_q + 1'b1;
          end

          pfat_pkg::KIND_RUN: begin
            if (!phase_q) begin
              if (!match) begin
                if (last_step) stat_d = pfat_pkg::STAT_NONE;
                addr_d = next_addr;
                cnt_d  = cnt_q + 1'b1;
              end else if (run_bad) begin
                stat_d = pfat_pkg::STAT_RUN;
              end else begin
                base_d  = addr_q;
                phase_d = 1'b1;
                if (len_q == CntW'(1)) begin
                  left_d = len_q;
                end else begin
                  addr_d = addr_q + 1'b1;
                  left_d = len_q - 1'b1;
                end
              end
            end else if (!e_free) begin
              stat_d = pfat_pkg::STAT_RUN;
            end else if (left_q == CntW'(1)) begin
              addr_d = base_q;
              left_d = len_q;
            end else begin
              addr_d = addr_q + 1'b1;
              left_d = left_q - 1'b1;
            end
          end

          default: begin
            // single-frame scans: reserve, claim, find, victim
            if (match) begin
              ridx_d = addr_q;
              case (kind_q)
                pfat_pkg::KIND_RESERVE: begin
                  wr.en          = 1'b1;
                  wr.addr        = addr_q;
                  wr.entry.ptype = pfat_pkg::TYPE_RESV;
                  wr.entry.owner = key_q;
                  free_d         = free_q - 1'b1;
                  rtype_d        = pfat_pkg::TYPE_RESV;
                  rown_d         = key_q;
                end
                pfat_pkg::KIND_CLAIM: begin
                  wr.en   = 1'b1;
                  wr.addr = addr_q;
                  if (claim_type == pfat_pkg::TYPE_FREE) begin
                    free_d = free_q + 1'b1;
                  end else begin
                    wr.entry.ptype = claim_type;
                    wr.entry.owner = key_q;
                    rtype_d        = claim_type;
                    rown_d         = key_q;
                  end
                end
                pfat_pkg::KIND_FIND: begin
                  curf_d  = addr_q;
                  rtype_d = ent.ptype;
                  rown_d  = ent.owner;
                end
                default: begin
                  cure_d  = addr_q;
                  rtype_d = ent.ptype;
                  rown_d  = ent.owner;
                end
              endcase
            end else begin
              if (last_step) stat_d = pfat_pkg::STAT_NONE;
              addr_d = next_addr;
              cnt_d  = cnt_q + 1'b1;
            end
          end
        endcase
      end

      pfat_pkg::ST_RUNWR: begin
        wr.en          = 1'b1;
        wr.addr        = addr_q;
        wr.entry.ptype = pfat_pkg::TYPE_RESV;
        wr.entry.owner = key_q;
        addr_d         = addr_q + 1'b1;
        left_d         = left_q - 1'b1;
        if (left_q == CntW'(1)) begin
          free_d  = free_q - len_q;
          ridx_d  = base_q;
          rtype_d = pfat_pkg::TYPE_RESV;
          rown_d  = key_q;
        end
      end

      default: ;
    endcase
  end

  // Effective frame count of a pages_in_use write
  logic [CntW-1:0] cfg_n;
  assign cfg_n = (cfg_data_i == '0) ? CntW'(1) :
                 (cfg_data_i > CntW'(pfat_pkg::NumPages)) ? CntW'(pfat_pkg::NumPages) :
                 cfg_data_i;
  assign tbl_clear = cfg_we_i && (cfg_addr_i == pfat_pkg::CFG_PAGES);

  // Control and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfat_pkg::ST_IDLE;
      free_q    <= CntW'(pfat_pkg::NumPages);
      n_q       <= CntW'(pfat_pkg::NumPages);
      lwm_q     <= CntW'(8);
      curf_q    <= '0;
      cure_q    <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
      phase_q   <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      phase_q <= phase_d;
      hit_q   <= hit_d;
      if (state_q == pfat_pkg::ST_FIN && fin_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (tbl_clear) begin
        n_q    <= cfg_n;
        free_q <= cfg_n;
        curf_q <= '0;
        cure_q <= '0;
      end else begin
        free_q <= free_d;
        curf_q <= curf_d;
        cure_q <= cure_d;
      end
      if (cfg_we_i && cfg_addr_i == pfat_pkg::CFG_LWM) begin
        lwm_q <= cfg_data_i;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    key_q   <= key_d;
    pt_q    <= pt_d;
    len_q   <= len_d;
    addr_q  <= addr_d;
    base_q  <= base_d;
    stat_q  <= stat_d;
    ridx_q  <= ridx_d;
    rtype_q <= rtype_d;
    rown_q  <= rown_d;
    if (state_q == pfat_pkg::ST_FIN && fin_load) begin
      out_q <= {(free_q < lwm_q), free_q, rown_q, rtype_q, ridx_q, stat_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  pfat_frame_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (tbl_clear),
    .rd_addr_i  (addr_q),
    .wr_i       (wr),
    .rd_entry_o (ent)
  );

endmodule
